// ===== rtl/core/prmd_pkg.sv =====
package prmd_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int DIST_WIDTH  = 25;

    // Differences need one bit more than a coordinate, magnitudes none extra.
    localparam int MAG_WIDTH   = COORD_WIDTH + 1;
    localparam int SQ_WIDTH    = 2 * MAG_WIDTH;
    localparam int SUM_WIDTH   = SQ_WIDTH + 1;
    // The radicand is the squared distance scaled by 4^FRAC_BITS.
    localparam int RAD_WIDTH   = SUM_WIDTH + 2 * FRAC_BITS;
    localparam int ROOT_BITS   = (RAD_WIDTH + 1) / 2;
    localparam int RAD_PAD     = 2 * ROOT_BITS;
    localparam int REM_WIDTH   = ROOT_BITS + 2;

    // One root bit is resolved per cell.
    typedef struct packed {
        logic [RAD_PAD-1:0]   rad;
        logic [REM_WIDTH-1:0] rem;
        logic [ROOT_BITS-1:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        logic                 valid;
        sqrt_lane_t           lo;
        sqrt_lane_t           hi;
        logic                 use_root;
        logic [DIST_WIDTH-1:0] edge_dist;
        logic                 in_rect;
    } cell_data_t;

endpackage

// ===== rtl/core/prmd_cell.sv =====
module prmd_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  prmd_pkg::cell_data_t din,
    output prmd_pkg::cell_data_t dout
);

    prmd_pkg::cell_data_t data_reg;
    prmd_pkg::cell_data_t data_next;

    function automatic prmd_pkg::sqrt_lane_t step(input prmd_pkg::sqrt_lane_t l);
        prmd_pkg::sqrt_lane_t o;
        logic [prmd_pkg::REM_WIDTH-1:0] trial;
        logic [prmd_pkg::REM_WIDTH-1:0] shifted;
        shifted = {l.rem[prmd_pkg::REM_WIDTH-3:0], l.rad[prmd_pkg::RAD_PAD-1 -: 2]};
        trial   = {l.root, 2'b01};
        o.rad   = {l.rad[prmd_pkg::RAD_PAD-3:0], 2'b00};
        if (shifted >= trial)
        begin
            o.rem  = shifted - trial;
            o.root = {l.root[prmd_pkg::ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            o.rem  = shifted;
            o.root = {l.root[prmd_pkg::ROOT_BITS-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb
    begin
        data_next    = din;
        data_next.lo = step(din.lo);
        data_next.hi = step(din.hi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '0;
        else if (advance)
            data_reg <= data_next;
    end

    assign dout = data_reg;

endmodule

// ===== rtl/core/prmd_front.sv =====
module prmd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                in_valid,
    input  logic signed [prmd_pkg::COORD_WIDTH-1:0] px,
    input  logic signed [prmd_pkg::COORD_WIDTH-1:0] py,
    input  logic signed [prmd_pkg::COORD_WIDTH-1:0] ax,
    input  logic signed [prmd_pkg::COORD_WIDTH-1:0] ay,
    input  logic signed [prmd_pkg::COORD_WIDTH-1:0] bx,
    input  logic signed [prmd_pkg::COORD_WIDTH-1:0] by,
    output prmd_pkg::cell_data_t                dout
);

    localparam int MW = prmd_pkg::MAG_WIDTH;
    localparam int SW = prmd_pkg::SQ_WIDTH;

    // Stage 1: differences, magnitudes and the span tests.
    logic          valid1_reg;
    logic [MW-1:0] ax1_reg, ax2_reg, ay1_reg, ay2_reg;
    logic          inx_reg, iny_reg;

    logic signed [MW-1:0] dx1, dx2, dy1, dy2;

    function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] d);
        return d[MW-1] ? MW'(-d) : MW'(d);
    endfunction

    function automatic logic between(input logic signed [MW-1:0] d1,
                                     input logic signed [MW-1:0] d2);
        return (d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0);
    endfunction

    always_comb
    begin
        dx1 = MW'(px) - MW'(ax);
        dx2 = MW'(px) - MW'(bx);
        dy1 = MW'(py) - MW'(ay);
        dy2 = MW'(py) - MW'(by);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid1_reg <= 1'b0;
        else if (advance)
            valid1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ax1_reg <= mag(dx1);
            ax2_reg <= mag(dx2);
            ay1_reg <= mag(dy1);
            ay2_reg <= mag(dy2);
            inx_reg <= between(dx1, dx2);
            iny_reg <= between(dy1, dy2);
        end
    end

    // Stage 2: squares and the near/far selection.
    logic          valid2_reg;
    logic [SW-1:0] qx1_reg, qx2_reg, qy1_reg, qy2_reg;
    logic          inx2_reg, iny2_reg;
    logic [MW-1:0] ex_reg, ey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid2_reg <= 1'b0;
        else if (advance)
            valid2_reg <= valid1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            qx1_reg  <= SW'(ax1_reg) * SW'(ax1_reg);
            qx2_reg  <= SW'(ax2_reg) * SW'(ax2_reg);
            qy1_reg  <= SW'(ay1_reg) * SW'(ay1_reg);
            qy2_reg  <= SW'(ay2_reg) * SW'(ay2_reg);
            inx2_reg <= inx_reg;
            iny2_reg <= iny_reg;
            ex_reg   <= (ax1_reg < ax2_reg) ? ax1_reg : ax2_reg;
            ey_reg   <= (ay1_reg < ay2_reg) ? ay1_reg : ay2_reg;
        end
    end

    logic [prmd_pkg::SUM_WIDTH-1:0] sum_lo, sum_hi;
    logic [prmd_pkg::MAG_WIDTH+prmd_pkg::FRAC_BITS-1:0] edge_full;

    always_comb
    begin
        sum_lo = prmd_pkg::SUM_WIDTH'((qx1_reg < qx2_reg) ? qx1_reg : qx2_reg)
               + prmd_pkg::SUM_WIDTH'((qy1_reg < qy2_reg) ? qy1_reg : qy2_reg);
        sum_hi = prmd_pkg::SUM_WIDTH'((qx1_reg > qx2_reg) ? qx1_reg : qx2_reg)
               + prmd_pkg::SUM_WIDTH'((qy1_reg > qy2_reg) ? qy1_reg : qy2_reg);
        edge_full = {(inx2_reg ? ey_reg : ex_reg), {prmd_pkg::FRAC_BITS{1'b0}}};

        dout.valid     = valid2_reg;
        dout.lo.rad    = prmd_pkg::RAD_PAD'({sum_lo, {2*prmd_pkg::FRAC_BITS{1'b0}}});
        dout.hi.rad    = prmd_pkg::RAD_PAD'({sum_hi, {2*prmd_pkg::FRAC_BITS{1'b0}}});
        dout.lo.rem    = '0;
        dout.hi.rem    = '0;
        dout.lo.root   = '0;
        dout.hi.root   = '0;
        dout.in_rect   = inx2_reg && iny2_reg;
        dout.use_root  = !inx2_reg && !iny2_reg;
        dout.edge_dist = (inx2_reg && iny2_reg) ? '0
                         : prmd_pkg::DIST_WIDTH'(edge_full);
    end

endmodule

// ===== rtl/core/point_rect_min_max_distance.sv =====
// Channel   Direction  Handshake        Payload
// in        input      valid / stall    point_x, point_y, corner_a/b_x/y
// out       output     out_valid/stall  min_distance, max_distance, strictly_inside
//
// One transfer per cycle is taken while the output is not stalled; a result
// passes through two front stages, one chain cell per root bit and the
// output register.
// The chain and front advance together whenever the output register is free or
// being drained; a stall on the output holds the whole pipeline in place.
// Reset clears the chain cells and the valid bits of the front and output stages.
module point_rect_min_max_distance (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   valid,
    output logic                                   stall,
    input  logic signed [prmd_pkg::COORD_WIDTH-1:0] point_x,
    input  logic signed [prmd_pkg::COORD_WIDTH-1:0] point_y,
    input  logic signed [prmd_pkg::COORD_WIDTH-1:0] corner_a_x,
    input  logic signed [prmd_pkg::COORD_WIDTH-1:0] corner_a_y,
    input  logic signed [prmd_pkg::COORD_WIDTH-1:0] corner_b_x,
    input  logic signed [prmd_pkg::COORD_WIDTH-1:0] corner_b_y,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [prmd_pkg::DIST_WIDTH-1:0]        min_distance,
    output logic [prmd_pkg::DIST_WIDTH-1:0]        max_distance,
    output logic                                   strictly_inside
);

    localparam int N = prmd_pkg::ROOT_BITS;

    logic advance;
    prmd_pkg::cell_data_t chain [0:N];

    assign advance = !(out_valid && out_stall);
    assign stall   = !advance;

    prmd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_valid(valid),
        .px      (point_x),
        .py      (point_y),
        .ax      (corner_a_x),
        .ay      (corner_a_y),
        .bx      (corner_b_x),
        .by      (corner_b_y),
        .dout    (chain[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        prmd_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .advance(advance),
            .din    (chain[i]),
            .dout   (chain[i+1])
        );
    end

    logic                          out_valid_reg;
    logic [prmd_pkg::DIST_WIDTH-1:0] min_reg, max_reg;
    logic                          in_rect_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= chain[N].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            min_reg     <= chain[N].use_root ? prmd_pkg::DIST_WIDTH'(chain[N].lo.root)
                                             : chain[N].edge_dist;
            max_reg     <= prmd_pkg::DIST_WIDTH'(chain[N].hi.root);
            in_rect_reg <= chain[N].in_rect;
        end
    end

    assign out_valid       = out_valid_reg;
    assign min_distance    = min_reg;
    assign max_distance    = max_reg;
    assign strictly_inside = in_rect_reg;

    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && strictly_inside |-> min_distance == '0)
        else $error("inside point with nonzero minimum distance");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> min_distance <= max_distance)
        else $error("minimum distance above maximum distance");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && out_stall) |-> $stable(chain[N].valid))
        else $error("chain moved during output stall");

endmodule
